// ===== rtl/core/mpqu_pkg.sv =====
// Package for the unsorted-list max priority queue.
// Holds payload structs, operation and status codes, and the sequencer state type.
// No dependencies.
`default_nettype none

package mpqu_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]          operation;
      logic signed [31:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  result_value;
      logic [1:0]          status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PEEK,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/mpqu_ram.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module mpqu_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic signed [31:0]   wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic signed [31:0]        rd_data
);

   logic signed [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mpqu_engine.sv =====
// Sequencer for the queue: push, peek, max scan and gap close over the entry store.
// Depends on mpqu_pkg and mpqu_ram.
`default_nettype none

module mpqu_engine #(
   parameter int CAPACITY = mpqu_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mpqu_pkg::req_type req_payload,
   output logic                   done_valid,
   input  wire logic              done_ready,
   output mpqu_pkg::rsp_type      done_payload
);
   import mpqu_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + 1;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic [AW-1:0]      arr_ff, arr_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic signed [31:0] best_ff, best_in;
   rsp_type            res_ff, res_in;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic signed [31:0] wr_data, rd_data;

   logic               scan_take;
   logic signed [31:0] fin_best;
   logic [AW-1:0]      fin_pos;

   mpqu_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // strict greater keeps the earliest of equal maxima
   assign scan_take = (arr_ff == '0) || (rd_data > best_ff);
   assign fin_best  = scan_take ? rd_data : best_ff;
   assign fin_pos   = scan_take ? arr_ff : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff  <= iss_in;
      arr_ff  <= arr_in;
      pos_ff  <= pos_in;
      wp_ff   <= wp_in;
      best_ff <= best_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      arr_in       = arr_ff;
      pos_in       = pos_ff;
      wp_in        = wp_ff;
      best_in      = best_ff;
      res_in       = res_ff;
      req_ready    = 1'b0;
      done_valid   = 1'b0;
      done_payload = res_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_payload.value;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in   = '{result_value: '0, status: STAT_OK};
               state_in = S_DONE;
               unique case (req_payload.operation)
                  OP_PUSH: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        iss_in   = CW'(1);
                        arr_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_PEEK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PEEK: begin
            res_in   = '{result_value: rd_data, status: STAT_OK};
            state_in = S_DONE;
         end
         S_SCAN: begin
            best_in = fin_best;
            pos_in  = fin_pos;
            if (iss_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = iss_ff[AW-1:0];
               iss_in  = iss_ff + 1'b1;
               arr_in  = iss_ff[AW-1:0];
            end
            if (CW'(arr_ff) == count_ff - 1'b1) begin
               if (XW'(fin_pos) + XW'(1) < XW'(count_ff)) begin
                  rd_en    = 1'b1;
                  rd_addr  = fin_pos + 1'b1;
                  wp_in    = fin_pos;
                  state_in = S_SHIFT;
               end else begin
                  count_in = count_ff - 1'b1;
                  res_in   = '{result_value: fin_best, status: STAT_OK};
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            // rd_data is entry wp+1; the next read is two ahead of the write
            wr_en   = 1'b1;
            wr_addr = wp_ff;
            wr_data = rd_data;
            if (XW'(wp_ff) + XW'(2) < XW'(count_ff)) begin
               rd_en   = 1'b1;
               rd_addr = wp_ff + AW'(2);
               wp_in   = wp_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               res_in   = '{result_value: best_ff, status: STAT_OK};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            done_valid = 1'b1;
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/max_priority_queue_unsorted_core.sv =====
// Max priority queue kept as an unsorted list of up to CAPACITY signed 32-bit
// values in arrival order, stored in one single-port-write, single-port-read
// memory with registered read data. A push appends at the back. A peek
// returns the oldest entry (not the maximum). A pop reads every held entry,
// one per cycle through the memory read port, to find the largest (the
// earliest wins a tie), then moves each later entry down by one, one memory
// read and write per cycle. Empty stores answer pop and peek with status
// empty, a push into a full store is dropped with status full, and operation
// code 3 is answered with status ok and no change. The store needs no
// clearing after reset; only entries below the fill count are ever read. One
// item is worked on at a time; a finished result sits in the output register
// and a new request is taken while it waits to be transferred.
// Depends on mpqu_pkg and mpqu_engine.
`default_nettype none

module max_priority_queue_unsorted_core #(
   parameter int CAPACITY = mpqu_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mpqu_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mpqu_pkg::rsp_type      rsp_payload
);
   import mpqu_pkg::*;

   logic    done_valid;
   logic    done_ready;
   rsp_type done_payload;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // sequencer: memory, fill count, scan and gap close
   mpqu_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .done_valid   (done_valid),
      .done_ready   (done_ready),
      .done_payload (done_payload)
   );

   // hand a finished result over when the output register is free or
   // being drained in this cycle
   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = done_payload;
      end else if (rsp_ready) begin
         // drop the entry once transferred
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload until the transfer completes
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
